// ===== design/grid_path_string_pull_unit_defines.svh =====
// assertion macros for the grid path string pull unit
// no dependencies; included by the top unit file, which checks its own logic
`ifndef GRID_PATH_STRING_PULL_UNIT_DEFINES_SVH
`define GRID_PATH_STRING_PULL_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GPSP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gpsp assertion failed");
// next-cycle implication
`define GPSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gpsp assertion failed");
`else
`define GPSP_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define GPSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/gpsp_pkg.sv =====
// shared types, constants and helpers of the grid path string pull unit
// no dependencies
package gpsp_pkg;

    localparam int GRID_DIM  = 64;
    localparam int MAX_PATH  = 64;
    localparam int COORD_W   = 6;
    localparam int GRID_AW   = $clog2(GRID_DIM);
    localparam int MAP_DEPTH = GRID_DIM * GRID_DIM;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int PATH_AW   = $clog2(MAX_PATH);
    localparam int CNT_W     = $clog2(MAX_PATH + 1);
    // signed working width of the line walker, holds coordinates and remainders
    localparam int EXT_W     = ((COORD_W > GRID_AW) ? COORD_W : GRID_AW) + 3;

    localparam logic OP_MAP  = 1'b0;
    localparam logic OP_PATH = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [COORD_W-1:0] map_x;
        logic [COORD_W-1:0] map_y;
        logic               walkable;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_z;
        logic               last_cell;
    } in_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] waypoint_x;
        logic [COORD_W-1:0] waypoint_y;
        logic [COORD_W-1:0] waypoint_z;
        logic               last_waypoint;
        logic               overflow;
    } out_word_t;

    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] from_x;
        logic [COORD_W-1:0] from_y;
        logic [COORD_W-1:0] to_x;
        logic [COORD_W-1:0] to_y;
    } sight_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic clear;
    } sight_rsp_t;

    // row-major map address, caller guarantees both coordinates are inside the grid
    function automatic logic [MAP_AW-1:0] map_addr(input logic [EXT_W-1:0] x,
                                                   input logic [EXT_W-1:0] y);
        return MAP_AW'(y) * MAP_AW'(GRID_DIM) + MAP_AW'(x);
    endfunction

endpackage

// ===== design/gpsp_sight.sv =====
// line of sight walker: incremental dda over the interior cells of a segment
// depends on gpsp_pkg; reads the walk map through a registered read port
module gpsp_sight (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  gpsp_pkg::sight_req_t       req,
    output gpsp_pkg::sight_rsp_t       rsp,
    output logic [gpsp_pkg::MAP_AW-1:0] map_rd_addr,
    input  logic                       map_rd_data
);

    localparam int RW = gpsp_pkg::EXT_W;
    localparam int CW = gpsp_pkg::COORD_W;
    localparam logic signed [RW-1:0] ONE  = RW'(1);
    localparam logic signed [RW-1:0] ZERO = RW'(0);
    localparam logic signed [RW-1:0] GRID = RW'(gpsp_pkg::GRID_DIM);

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_FETCH, S_CHECK} state_t;

    typedef struct packed {
        logic signed [RW-1:0] q;
        logic signed [RW-1:0] r;
    } dda_t;

    // one step of the rounded dda: remainder stays in [0, 2*steps)
    function automatic dda_t dda_step(input dda_t cur, input logic signed [RW-1:0] d2,
                                      input logic signed [RW-1:0] s2);
        dda_t                 nxt;
        logic signed [RW-1:0] rs;
        rs    = cur.r + d2;
        nxt.q = cur.q;
        nxt.r = rs;
        if (rs >= s2) begin
            nxt.q = cur.q + ONE;
            nxt.r = rs - s2;
        end else if (rs < ZERO) begin
            nxt.q = cur.q - ONE;
            nxt.r = rs + s2;
        end
        return nxt;
    endfunction

    state_t               state_reg;
    logic [CW-1:0]        fx_reg, fy_reg, steps_reg, i_reg;
    logic signed [RW-1:0] d2x_reg, d2y_reg, s2_reg;
    dda_t                 dx_reg, dy_reg;
    logic                 oob_reg, done_reg, clear_reg;
    logic [gpsp_pkg::MAP_AW-1:0] addr_reg;

    logic signed [RW-1:0] fxe, fye, txe, tye, ddx, ddy, adx, ady, stp;
    dda_t                 nx, ny;
    logic signed [RW-1:0] cx, cy;
    logic                 coord_oob;

    always_comb begin
        fxe = signed'(RW'(req.from_x));
        fye = signed'(RW'(req.from_y));
        txe = signed'(RW'(req.to_x));
        tye = signed'(RW'(req.to_y));
        ddx = txe - fxe;
        ddy = tye - fye;
        adx = (ddx < ZERO) ? -ddx : ddx;
        ady = (ddy < ZERO) ? -ddy : ddy;
        stp = (adx > ady) ? adx : ady;
        nx  = dda_step(dx_reg, d2x_reg, s2_reg);
        ny  = dda_step(dy_reg, d2y_reg, s2_reg);
        cx  = signed'(RW'(fx_reg)) + nx.q;
        cy  = signed'(RW'(fy_reg)) + ny.q;
        coord_oob = (cx < ZERO) || (cx >= GRID) || (cy < ZERO) || (cy >= GRID);
    end

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            clear_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (req.start) begin
                        fx_reg    <= req.from_x;
                        fy_reg    <= req.from_y;
                        steps_reg <= stp[CW-1:0];
                        s2_reg    <= stp <<< 1;
                        d2x_reg   <= ddx <<< 1;
                        d2y_reg   <= ddy <<< 1;
                        dx_reg    <= '{q: ZERO, r: stp};
                        dy_reg    <= '{q: ZERO, r: stp};
                        i_reg     <= CW'(1);
                        if (stp <= ONE) begin
                            // no interior cells
                            done_reg  <= 1'b1;
                            clear_reg <= 1'b1;
                        end else begin
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: begin
                    dx_reg    <= nx;
                    dy_reg    <= ny;
                    oob_reg   <= coord_oob;
                    addr_reg  <= gpsp_pkg::map_addr(cx, cy);
                    state_reg <= S_FETCH;
                end
                S_FETCH: begin
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    if (oob_reg || !map_rd_data) begin
                        done_reg  <= 1'b1;
                        clear_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end else if (i_reg == steps_reg - CW'(1)) begin
                        done_reg  <= 1'b1;
                        clear_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_ISSUE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign map_rd_addr = addr_reg;
    assign rsp.busy    = (state_reg != S_IDLE);
    assign rsp.done    = done_reg;
    assign rsp.clear   = clear_reg;

endmodule

// ===== design/grid_path_string_pull_unit.sv =====
// grid path string pull unit: walk map, path store, waypoint sequencer
// order: map writes and path cells are stored as they are accepted; after the last cell the
// waypoints follow, each sight test stepping through issue, fetch and check per interior cell
// throughput: one input word per cycle while loading, none during the smoothing burst
// reset: a clearing pass writes every walk map cell blocked, with s_ready low; depends on
// gpsp_pkg, gpsp_sight and the defines header
`include "grid_path_string_pull_unit_defines.svh"
module grid_path_string_pull_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gpsp_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gpsp_pkg::out_word_t m_data
);

    localparam int CW  = gpsp_pkg::COORD_W;
    localparam int PAW = gpsp_pkg::PATH_AW;
    localparam int NW  = gpsp_pkg::CNT_W;
    localparam int MAW = gpsp_pkg::MAP_AW;
    localparam int EW  = gpsp_pkg::EXT_W;

    typedef enum logic [3:0] {
        T_CLEAR, T_IDLE, T_RD_WP, T_LD_WP, T_OUT, T_RD_CAND, T_LD_CAND, T_SIGHT
    } state_t;

    state_t               state_reg;
    logic [NW-1:0]        count_reg, n_reg;
    logic                 dropped_reg;
    logic [PAW-1:0]       cur_reg, cand_reg, wp_idx_reg, praddr_reg;
    logic [CW-1:0]        curx_reg, cury_reg;
    logic [MAW-1:0]       clr_addr_reg;
    logic                 m_valid_reg;
    gpsp_pkg::out_word_t  m_data_reg;
    gpsp_pkg::sight_req_t req_reg;
    gpsp_pkg::sight_rsp_t rsp;

    // walk map, one bit per cell
    logic                 map_mem [gpsp_pkg::MAP_DEPTH];
    logic                 map_q_reg;
    logic [MAW-1:0]       map_raddr;
    logic                 map_we, map_wdata;
    logic [MAW-1:0]       map_waddr;

    // path store: x, y, z
    logic [3*CW-1:0]      path_mem [gpsp_pkg::MAX_PATH];
    logic [3*CW-1:0]      path_q_reg;
    logic                 path_we;

    logic                 accept, map_in_grid, room;
    logic [NW-1:0]        n_new, cur_p1, cand_m1;
    logic [CW-1:0]        pq_x, pq_y, pq_z;

    assign s_ready = (state_reg == T_IDLE);
    assign accept  = s_valid && s_ready;
    assign room    = (count_reg < NW'(gpsp_pkg::MAX_PATH));
    assign map_in_grid = (EW'(s_data.map_x) < EW'(gpsp_pkg::GRID_DIM)) &&
                         (EW'(s_data.map_y) < EW'(gpsp_pkg::GRID_DIM));
    assign n_new   = room ? count_reg + NW'(1) : count_reg;
    assign cur_p1  = NW'(cur_reg) + NW'(1);
    assign cand_m1 = NW'(cand_reg) - NW'(1);
    assign {pq_x, pq_y, pq_z} = path_q_reg;

    // map write port: clearing pass, or a map write word in range
    always_comb begin
        map_we    = 1'b0;
        map_waddr = clr_addr_reg;
        map_wdata = 1'b0;
        if (state_reg == T_CLEAR) begin
            map_we = 1'b1;
        end else if (accept && s_data.operation == gpsp_pkg::OP_MAP && map_in_grid) begin
            map_we    = 1'b1;
            map_waddr = gpsp_pkg::map_addr(EW'(s_data.map_x), EW'(s_data.map_y));
            map_wdata = s_data.walkable;
        end
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_q_reg <= map_mem[map_raddr];
    end

    assign path_we = accept && s_data.operation == gpsp_pkg::OP_PATH && room;

    always_ff @(posedge aclk) begin
        if (path_we) begin
            path_mem[count_reg[PAW-1:0]] <= {s_data.cell_x, s_data.cell_y, s_data.cell_z};
        end
        path_q_reg <= path_mem[praddr_reg];
    end

    // main sequencer
    always_ff @(posedge aclk) begin
        req_reg.start <= 1'b0;
        if (!aresetn) begin
            state_reg    <= T_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                T_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + MAW'(1);
                    if (clr_addr_reg == MAW'(gpsp_pkg::MAP_DEPTH - 1)) begin
                        state_reg <= T_IDLE;
                    end
                end
                T_IDLE: begin
                    if (accept && s_data.operation == gpsp_pkg::OP_PATH) begin
                        count_reg <= n_new;
                        if (!room) begin
                            dropped_reg <= 1'b1;
                        end
                        if (s_data.last_cell) begin
                            if (n_new == '0) begin
                                // empty run: nothing to emit
                                count_reg   <= '0;
                                dropped_reg <= 1'b0;
                            end else begin
                                n_reg      <= n_new;
                                wp_idx_reg <= '0;
                                praddr_reg <= '0;
                                state_reg  <= T_RD_WP;
                            end
                        end
                    end
                end
                T_RD_WP: begin
                    state_reg <= T_LD_WP;
                end
                T_LD_WP: begin
                    m_data_reg.waypoint_x    <= pq_x;
                    m_data_reg.waypoint_y    <= pq_y;
                    m_data_reg.waypoint_z    <= pq_z;
                    m_data_reg.last_waypoint <= (NW'(wp_idx_reg) + NW'(1) == n_reg);
                    m_data_reg.overflow      <= dropped_reg;
                    m_valid_reg              <= 1'b1;
                    // the emitted cell becomes the current waypoint
                    curx_reg  <= pq_x;
                    cury_reg  <= pq_y;
                    cur_reg   <= wp_idx_reg;
                    state_reg <= T_OUT;
                end
                T_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (m_data_reg.last_waypoint) begin
                            count_reg   <= '0;
                            dropped_reg <= 1'b0;
                            state_reg   <= T_IDLE;
                        end else if (n_reg - NW'(1) > cur_p1) begin
                            // scan back from the end of the path
                            cand_reg   <= PAW'(n_reg - NW'(1));
                            praddr_reg <= PAW'(n_reg - NW'(1));
                            state_reg  <= T_RD_CAND;
                        end else begin
                            wp_idx_reg <= PAW'(cur_p1);
                            praddr_reg <= PAW'(cur_p1);
                            state_reg  <= T_RD_WP;
                        end
                    end
                end
                T_RD_CAND: begin
                    state_reg <= T_LD_CAND;
                end
                T_LD_CAND: begin
                    req_reg.start  <= 1'b1;
                    req_reg.from_x <= curx_reg;
                    req_reg.from_y <= cury_reg;
                    req_reg.to_x   <= pq_x;
                    req_reg.to_y   <= pq_y;
                    state_reg      <= T_SIGHT;
                end
                T_SIGHT: begin
                    if (rsp.done) begin
                        if (rsp.clear) begin
                            wp_idx_reg <= cand_reg;
                            praddr_reg <= cand_reg;
                            state_reg  <= T_RD_WP;
                        end else if (cand_m1 > cur_p1) begin
                            cand_reg   <= PAW'(cand_m1);
                            praddr_reg <= PAW'(cand_m1);
                            state_reg  <= T_RD_CAND;
                        end else begin
                            // nothing farther in sight: take the next cell
                            wp_idx_reg <= PAW'(cur_p1);
                            praddr_reg <= PAW'(cur_p1);
                            state_reg  <= T_RD_WP;
                        end
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    gpsp_sight u_sight (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (req_reg),
        .rsp         (rsp),
        .map_rd_addr (map_raddr),
        .map_rd_data (map_q_reg)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // no intake while a waypoint word is pending
    `GPSP_ASSERT_IMPL(a_no_intake_while_out, aclk, aresetn, s_ready, !m_valid_reg)
    // final waypoint taken empties the path store
    `GPSP_ASSERT_NEXT(a_run_ends_empty, aclk, aresetn,
        m_valid && m_ready && m_data.last_waypoint, count_reg == '0 && !dropped_reg)
    // sight result only arrives while waiting on it
    `GPSP_ASSERT_IMPL(a_sight_done_in_wait, aclk, aresetn, rsp.done, state_reg == T_SIGHT)

endmodule
